>>> src/fp8s_pkg.sv
package fp8s_pkg;

  localparam int unsigned CodeW   = 8;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned Bf16W   = 16;
  localparam int unsigned ProdW   = 28;
  localparam int unsigned MaxLanes = 4;

  localparam logic [7:0]  ScaleExpMax = 8'hFF;
  localparam logic [31:0] F32InfMag   = 32'h7F80_0000;
  localparam logic [31:0] Bf16Half    = 32'h0000_8000;
  localparam logic [15:0] Bf16QNan    = 16'h7FC0;
  localparam logic [14:0] Bf16InfMag  = 15'h7F80;

  // Position of the leading one of a nonzero product.
  function automatic logic [4:0] lead_one(input logic [ProdW-1:0] x);
    logic [4:0] pos;
    pos = '0;
    for (int i = 0; i < ProdW; i++) begin
      if (x[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

>>> src/fp8s_lane.sv
module fp8s_lane
  import fp8s_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CodeW-1:0]  code,
  input  logic [ScaleW-1:0] scale_bits,
  output logic [Bf16W-1:0]  value
);

  // Stage one: decode both operands and form the exact significand product.
  logic [3:0]        a_sig;
  logic [23:0]       b_sig;
  logic signed [9:0] a_exp;
  logic signed [9:0] b_exp;
  logic [7:0]        s_exp;
  logic              s_man_nz;

  always_comb begin
    s_exp    = scale_bits[30:23];
    s_man_nz = (scale_bits[22:0] != '0);
    a_sig    = {(code[6:3] != '0), code[2:0]};
    a_exp    = (code[6:3] != '0) ? (10'(signed'({1'b0, code[6:3]})) - 10'sd10) : -10'sd9;
    b_sig    = {(s_exp != '0), scale_bits[22:0]};
    b_exp    = (s_exp != '0) ? (10'(signed'({1'b0, s_exp})) - 10'sd150) : -10'sd149;
  end

  logic [ProdW-1:0]  s1_prod;
  logic signed [9:0] s1_exp;
  logic              s1_sign;
  logic              s1_nan;
  logic              s1_inf;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= ProdW'(a_sig) * ProdW'(b_sig);
      s1_exp  <= a_exp + b_exp;
      s1_sign <= code[7] ^ scale_bits[31];
      s1_nan  <= (s_exp == ScaleExpMax) && (s_man_nz || (a_sig == '0));
      s1_inf  <= (s_exp == ScaleExpMax) && !s_man_nz && (a_sig != '0);
    end
  end

  // Stage two: pick the alignment, normal or subnormal, and shift.
  logic [4:0]        lead;
  logic signed [9:0] biased;
  logic signed [9:0] d_norm;
  logic signed [9:0] d_sub;
  logic signed [9:0] d;
  logic [8:0]        base;
  logic [36:0]       rshift;
  logic [50:0]       lshift;
  logic [9:0]        neg_d;
  logic [23:0]       q0;
  logic              guard;
  logic              sticky;

  always_comb begin
    lead   = lead_one(s1_prod);
    biased = 10'(signed'({5'b0, lead})) + s1_exp + 10'sd127;
    d_norm = 10'(signed'({5'b0, lead})) - 10'sd23;
    d_sub  = -(s1_exp + 10'sd149);
    d      = (d_sub > d_norm) ? d_sub : d_norm;
    base   = (biased <= 10'sd0) ? 9'd0 : 9'(biased - 10'sd1);
    rshift = {s1_prod, 9'b0} >> d[3:0];
    neg_d  = 10'(-d);
    lshift = {23'b0, s1_prod} << neg_d[4:0];
    if (d > 10'sd0) begin
      q0     = rshift[32:9];
      guard  = rshift[8];
      sticky = (rshift[7:0] != '0);
    end else begin
      q0     = lshift[23:0];
      guard  = 1'b0;
      sticky = 1'b0;
    end
  end

  logic [23:0] s2_q;
  logic        s2_guard;
  logic        s2_sticky;
  logic [8:0]  s2_base;
  logic        s2_zero;
  logic        s2_sign;
  logic        s2_nan;
  logic        s2_inf;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_q      <= q0;
      s2_guard  <= guard;
      s2_sticky <= sticky;
      s2_base   <= base;
      s2_zero   <= (s1_prod == '0);
      s2_sign   <= s1_sign;
      s2_nan    <= s1_nan;
      s2_inf    <= s1_inf;
    end
  end

  // Stage three: round to nearest even in FP32, then to BF16 with ties away.
  logic [24:0] q;
  logic [31:0] enc;
  logic [30:0] mag;
  logic [31:0] rnd;
  logic [15:0] bf;

  always_comb begin
    q   = {1'b0, s2_q} + 25'(s2_guard & (s2_sticky | s2_q[0]));
    enc = {s2_base, 23'b0} + {7'b0, q};
    if (s2_zero) begin
      mag = '0;
    end else if (enc >= F32InfMag) begin
      mag = F32InfMag[30:0];
    end else begin
      mag = enc[30:0];
    end
    rnd = {s2_sign, mag} + Bf16Half;
    if (s2_nan) begin
      bf = Bf16QNan;
    end else if (s2_inf) begin
      bf = {s2_sign, Bf16InfMag};
    end else begin
      bf = rnd[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= bf;
    end
  end

endmodule

>>> src/fp8_e4m3_scaled_to_bf16_top.sv
// Channel | Ports                                   | Direction
// in      | in_valid, in_ready, codes, scale_bits,  | into the block
//         | last_in                                 |
// out     | out_valid, out_ready, values, last_out  | out of the block
//
// A beat enters every cycle while the output is not held; each result
// passes through the three register stages of each lane (stage one, stage
// two and the output register) before it leaves the block.
// All lanes work on the same beat in parallel and share one stall enable.
// When the output beat is held, the whole pipeline holds and in_ready falls.
// Reset clears only the stage valid flags; the data registers need none.
module fp8_e4m3_scaled_to_bf16_top
  import fp8s_pkg::*;
#(
  parameter int unsigned LANES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] codes,
  input  logic [31:0] scale_bits,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] values,
  output logic        last_out
);

  logic       en;
  logic [2:0] vld;
  logic [2:0] lst;

  assign en        = !vld[2] || out_ready;
  assign in_ready  = en && !rst;
  assign out_valid = vld[2];
  assign last_out  = lst[2];

  // Valid flags travel with each beat through the lane stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst <= {lst[1:0], last_in};
    end
  end

  // One converter per active lane; the merged word gathers their results.
  for (genvar k = 0; k < MaxLanes; k++) begin : g_lane
    if (k < LANES) begin : g_on
      fp8s_lane u_lane (
        .clk        (clk),
        .en         (en),
        .code       (codes[CodeW*k +: CodeW]),
        .scale_bits (scale_bits),
        .value      (values[Bf16W*k +: Bf16W])
      );
    end else begin : g_off
      assign values[Bf16W*k +: Bf16W] = '0;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted beat did not enter the first stage");

  a_stage_reaches_out: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && en) |=> out_valid)
    else $error("beat lost between last stage and output");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((values >> (Bf16W * LANES)) == 64'd0))
    else $error("unused lane not zero");

endmodule
